// ===== src/kgr_pkg.sv =====
// ----------------------------------------------------------------------------
// kgr_pkg
// Shared widths, register indexes and pipeline types of the ghost key resolver.
// ----------------------------------------------------------------------------
package kgr_pkg;

    localparam int MAX_ROWS   = 8;
    localparam int MAX_COLS   = 8;
    localparam int COL_W      = 8;
    localparam int KEY_W      = MAX_ROWS * COL_W;
    localparam int DEF_ROWS   = 8;
    localparam int DEF_COLS   = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int ACOLS_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_GHOST_ENABLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLS  = 8'd1;

    localparam logic               GHOST_ENABLE_RESET = 1'b0;
    localparam logic [ACOLS_W-1:0] ACTIVE_COLS_RESET  = 4'd8;

    typedef struct packed {
        logic               ghost_enable;
        logic [ACOLS_W-1:0] active_cols;
    } kgr_cfg_t;

    // one request in flight: the queried data, the reach so far, the column mask
    // and the node rows (all zero when ghosting is gated off)
    typedef struct packed {
        logic [COL_W-1:0]                data;
        logic [COL_W-1:0]                reach;
        logic [COL_W-1:0]                mask;
        logic [MAX_ROWS-1:0][COL_W-1:0] nodes;
    } kgr_item_t;

endpackage

// ===== src/kgr_query_if.sv =====
// ----------------------------------------------------------------------------
// kgr_query_if
// Request channel: key matrix, queried rows and the columns read on them.
// ----------------------------------------------------------------------------
interface kgr_query_if
    import kgr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KEY_W-1:0]    key_rows;
    logic [MAX_ROWS-1:0] query_rows;
    logic [COL_W-1:0]    queried_columns;

    modport source (output valid, key_rows, query_rows, queried_columns, input ready);
    modport sink   (input valid, key_rows, query_rows, queried_columns, output ready);
endinterface

// ===== src/kgr_result_if.sv =====
// ----------------------------------------------------------------------------
// kgr_result_if
// Result channel: columns seen including ghosts, and the ghost flag.
// ----------------------------------------------------------------------------
interface kgr_result_if
    import kgr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] column_data;
    logic             ghosts_added;

    modport source (output valid, column_data, ghosts_added, input ready);
    modport sink   (input valid, column_data, ghosts_added, output ready);
endinterface

// ===== src/kgr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// kgr_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface kgr_cfg_if
    import kgr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/keypad_ghost_key_resolver.sv =====
// ----------------------------------------------------------------------------
// keypad_ghost_key_resolver
// Ghost key model for a key matrix: closure over rows that share columns.
// ----------------------------------------------------------------------------
// Usage:
//   query  - request channel: key_rows, query_rows, queried_columns
//   result - column_data and ghosts_added, one result per request, in order
//   cfg    - register writes (index 0 ghost_enable, index 1 active_cols);
//            always ready, write only while no request is in flight
// Throughput: one request per cycle while result.ready holds. Stages: a prep
//   stage, closure stages of two merge steps each, since a full closure needs
//   ROWS merge steps, and a registered output stage.
// Every stage holds its own valid bit; a bubble is filled even while the
//   receiver stalls, and a full pipe holds its requests until result.ready.
// Reset clears all valid bits, ghost_enable to 0 and active_cols to 8.
// ----------------------------------------------------------------------------
module keypad_ghost_key_resolver
    import kgr_pkg::*;
#(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
)
(
    input  logic         clk,
    input  logic         rst_n,
    kgr_query_if.sink    query,
    kgr_result_if.source result,
    kgr_cfg_if.sink      cfg
);

    localparam int CL_STAGES = (ROWS + 1) / 2;

    kgr_cfg_t  regs;
    logic      st_valid [CL_STAGES+1];
    logic      st_ready [CL_STAGES+1];
    kgr_item_t st_item  [CL_STAGES+1];

    kgr_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    kgr_prep #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_prep (
        .clk   (clk),
        .rst_n (rst_n),
        .query (query),
        .regs  (regs),
        .valid (st_valid[0]),
        .item  (st_item[0]),
        .ready (st_ready[0])
    );

    for (genvar g = 0; g < CL_STAGES; g++)
    begin : g_closure
        kgr_closure_stage #(
            .ROWS  (ROWS),
            .STEPS (2)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (st_valid[g]),
            .up_item  (st_item[g]),
            .up_ready (st_ready[g]),
            .dn_valid (st_valid[g+1]),
            .dn_item  (st_item[g+1]),
            .dn_ready (st_ready[g+1])
        );
    end

    kgr_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (st_valid[CL_STAGES]),
        .up_item  (st_item[CL_STAGES]),
        .up_ready (st_ready[CL_STAGES]),
        .result   (result)
    );

endmodule

// ===== src/kgr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// kgr_cfg_regs
// Configuration registers: ghost enable and active column count.
// ----------------------------------------------------------------------------
module kgr_cfg_regs
    import kgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    kgr_cfg_if.sink    cfg,
    output kgr_cfg_t   regs
);

    kgr_cfg_t regs_reg;
    kgr_cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_GHOST_ENABLE: regs_next.ghost_enable = cfg.data[0];
                REG_ACTIVE_COLS:  regs_next.active_cols  = cfg.data[ACOLS_W-1:0];
                default:          regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.ghost_enable <= GHOST_ENABLE_RESET;
            regs_reg.active_cols  <= ACTIVE_COLS_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== src/kgr_prep.sv =====
// ----------------------------------------------------------------------------
// kgr_prep
// First stage: column mask, ghosting gate and extraction of the node rows.
// ----------------------------------------------------------------------------
module kgr_prep
    import kgr_pkg::*;
#(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
)
(
    input  logic       clk,
    input  logic       rst_n,
    kgr_query_if.sink  query,
    input  kgr_cfg_t   regs,
    output logic       valid,
    output kgr_item_t  item,
    input  logic       ready
);

    localparam logic [COL_W-1:0] COLS_MASK = COL_W'((1 << COLS) - 1);

    logic      valid_reg;
    kgr_item_t item_reg;
    kgr_item_t item_next;
    logic      run;
    logic      advance;

    assign advance     = !valid_reg || ready;
    assign query.ready = advance;
    assign valid       = valid_reg;
    assign item        = item_reg;

    always_comb
    begin
        logic [COL_W-1:0] row;
        item_next.data  = query.queried_columns;
        item_next.reach = query.queried_columns;
        for (int c = 0; c < COL_W; c++)
        begin
            item_next.mask[c] = (c < COLS) && (c < int'(regs.active_cols));
        end
        run = regs.ghost_enable && (query.queried_columns != '0)
            && ((query.queried_columns & item_next.mask) != item_next.mask);
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            row = query.key_rows[r*COL_W +: COL_W] & COLS_MASK;
            // a node is an unqueried row holding two or more keys
            if (run && (r < ROWS) && !query.query_rows[r] && ((row & (row - 1'b1)) != '0))
                item_next.nodes[r] = row;
            else
                item_next.nodes[r] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= query.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && query.valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== src/kgr_closure_stage.sv =====
// ----------------------------------------------------------------------------
// kgr_closure_stage
// One pipeline stage of the reachability closure, STEPS expansion steps deep.
// ----------------------------------------------------------------------------
module kgr_closure_stage
    import kgr_pkg::*;
#(
    parameter int ROWS  = DEF_ROWS,
    parameter int STEPS = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    input  kgr_item_t  up_item,
    output logic       up_ready,
    output logic       dn_valid,
    output kgr_item_t  dn_item,
    input  logic       dn_ready
);

    logic      valid_reg;
    kgr_item_t item_reg;
    kgr_item_t item_next;
    logic      advance;

    assign advance  = !valid_reg || dn_ready;
    assign up_ready = advance;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

    // each step merges every node touching the reach, so at least one new
    // node joins per step until the closure is complete
    always_comb
    begin
        logic [COL_W-1:0] hit;
        item_next = up_item;
        for (int s = 0; s < STEPS; s++)
        begin
            hit = '0;
            for (int r = 0; r < ROWS; r++)
            begin
                if ((up_item.nodes[r] & item_next.reach) != '0)
                    hit = hit | up_item.nodes[r];
            end
            item_next.reach = item_next.reach | hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== src/kgr_out_stage.sv =====
// ----------------------------------------------------------------------------
// kgr_out_stage
// Last stage: masks the reach to the active columns and flags added ghosts.
// ----------------------------------------------------------------------------
module kgr_out_stage
    import kgr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    input  kgr_item_t    up_item,
    output logic         up_ready,
    kgr_result_if.source result
);

    logic             valid_reg;
    logic [COL_W-1:0] column_data_reg;
    logic [COL_W-1:0] column_data_next;
    logic             ghosts_added_reg;
    logic             ghosts_added_next;
    logic             advance;

    assign advance             = !valid_reg || result.ready;
    assign up_ready            = advance;
    assign result.valid        = valid_reg;
    assign result.column_data  = column_data_reg;
    assign result.ghosts_added = ghosts_added_reg;

    assign column_data_next  = up_item.reach & up_item.mask;
    assign ghosts_added_next = |(column_data_next & ~up_item.data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            column_data_reg  <= column_data_next;
            ghosts_added_reg <= ghosts_added_next;
        end
    end

endmodule

// ===== test/keypad_ghost_key_resolver_tb.sv =====
// ----------------------------------------------------------------------------
// keypad_ghost_key_resolver_tb
// Drives key matrix requests through the ghost key resolver and checks every
// result against a closure computed in the bench, over several register
// settings, with random idling on both channels and one long receiver stall.
// ----------------------------------------------------------------------------
module keypad_ghost_key_resolver_tb;
    import kgr_pkg::*;

    localparam int N_ROWS      = DEF_ROWS;
    localparam int N_COLS      = DEF_COLS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 86;

    // index that maps to no register, written once to see it ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hA5;

    typedef struct packed {
        logic [KEY_W-1:0]    keys;
        logic [MAX_ROWS-1:0] rows;
        logic [COL_W-1:0]    data;
    } query_t;

    typedef struct packed {
        logic [COL_W-1:0] column_data;
        logic             ghosts_added;
    } column_result_t;

    class ghost_column_board;
        kgr_cfg_t       regs = '{GHOST_ENABLE_RESET, ACTIVE_COLS_RESET};
        column_result_t expected_columns[$];
        int             errors  = 0;

        function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_GHOST_ENABLE)
                regs.ghost_enable = value[0];
            else if (idx == REG_ACTIVE_COLS)
                regs.active_cols = value[ACOLS_W-1:0];
        endfunction

        function column_result_t resolve_columns(query_t qi);
            column_result_t   res;
            logic [COL_W-1:0] mask;
            logic [COL_W-1:0] valid_cols;
            logic [COL_W-1:0] reach;
            logic [COL_W-1:0] row;
            int               n;
            n = (regs.active_cols > N_COLS) ? N_COLS : int'(regs.active_cols);
            mask       = '0;
            valid_cols = '0;
            for (int c = 0; c < n; c++)
                mask[c] = 1'b1;
            for (int c = 0; c < N_COLS; c++)
                valid_cols[c] = 1'b1;
            reach = qi.data;
            if (regs.ghost_enable && qi.data != '0 && (qi.data & mask) != mask) begin
                // unqueried rows with two or more keys bridge the columns they share
                for (int pass = 0; pass <= N_ROWS; pass++)
                    for (int r = 0; r < N_ROWS; r++) begin
                        row = qi.keys[COL_W*r +: COL_W] & valid_cols;
                        if (!qi.rows[r] && $countones(row) >= 2 && (row & reach) != '0)
                            reach |= row;
                    end
            end
            res.column_data  = reach & mask;
            res.ghosts_added = |(res.column_data & ~qi.data);
            return res;
        endfunction

        function void note_request(query_t qi);
            expected_columns.push_back(resolve_columns(qi));
        endfunction

        function void flag_error();
            errors++;
        endfunction

        function void check_result(logic [COL_W-1:0] col, logic ghost);
            column_result_t want;
            if (expected_columns.size() == 0) begin
                flag_error();
                $display("%0t: result with no request pending, expected none, actual %02h/%0b",
                         $time, col, ghost);
                return;
            end
            want = expected_columns.pop_front();
            if (col !== want.column_data) begin
                flag_error();
                $display("%0t: column_data expected %02h actual %02h",
                         $time, want.column_data, col);
            end
            if (ghost !== want.ghosts_added) begin
                flag_error();
                $display("%0t: ghosts_added expected %0b actual %0b",
                         $time, want.ghosts_added, ghost);
            end
        endfunction

        function int pending();
            return expected_columns.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    kgr_query_if  query_bus ();
    kgr_result_if result_bus ();
    kgr_cfg_if    cfg_bus ();

    keypad_ghost_key_resolver #(
        .ROWS (N_ROWS),
        .COLS (N_COLS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    ghost_column_board sb = new;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off_req  = 1'b0;
    int hold_cnt      = 0;
    int cycles        = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL keypad_ghost_key_resolver");
        $finish;
    end

    // receiver: checks each accepted result, then picks ready for the next edge
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready)
                sb.check_result(result_bus.column_data, result_bus.ghosts_added);
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                result_bus.ready <= 1'b0;
            end
            else if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_cnt     = HOLD_CYCLES;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic offer_query(input query_t qi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            query_bus.valid <= 1'b0;
            @(posedge clk);
        end
        query_bus.valid           <= 1'b1;
        query_bus.key_rows        <= qi.keys;
        query_bus.query_rows      <= qi.rows;
        query_bus.queried_columns <= qi.data;
        @(posedge clk);
        while (!query_bus.ready)
            @(posedge clk);
        sb.note_request(qi);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        sb.apply_write(idx, value);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] en_val,
                              input logic [CFG_DATA_W-1:0] cols_val);
        write_reg(REG_GHOST_ENABLE, en_val);
        write_reg(REG_ACTIVE_COLS, cols_val);
        cfg_bus.valid <= 1'b0;
    endtask

    // drop valid, wait for every result, then let the pipe run dry
    task automatic finish_phase();
        query_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic query_t make_query();
        query_t           qi;
        logic [COL_W-1:0] row;
        int               kind;
        kind = $urandom_range(99);
        qi   = '0;
        if (kind < 70)
        begin
            // scan-like request: data is the OR of the queried rows, at times with one column set or flipped
            for (int r = 0; r < MAX_ROWS; r++)
            begin
                case ($urandom_range(3))
                    0: row = '0;
                    1: row = COL_W'(1 << $urandom_range(COL_W-1));
                    2: row = COL_W'($urandom) & COL_W'($urandom);
                    default: row = COL_W'($urandom);
                endcase
                qi.keys[COL_W*r +: COL_W] = row;
                qi.rows[r] = ($urandom_range(3) == 0);
                if (qi.rows[r])
                    qi.data |= row;
            end
            if (qi.data == '0 && $urandom_range(1))
                qi.data = COL_W'(1 << $urandom_range(COL_W-1));
            if ($urandom_range(9) == 0)
                qi.data[$urandom_range(COL_W-1)] ^= 1'b1;
        end
        else if (kind < 85)
        begin
            qi.keys = {$urandom, $urandom};
            qi.rows = MAX_ROWS'($urandom);
            qi.data = COL_W'($urandom);
        end
        else
        begin
            // mostly two-key rows, nothing queried, a single column seen
            for (int r = 0; r < MAX_ROWS; r++)
            begin
                row = COL_W'(1 << $urandom_range(COL_W-1));
                row[$urandom_range(COL_W-1)] = 1'b1;
                qi.keys[COL_W*r +: COL_W] = row;
            end
            qi.data = COL_W'(1 << $urandom_range(COL_W-1));
        end
        return qi;
    endfunction

    initial
    begin
        logic [CFG_DATA_W-1:0] en_val;
        logic [CFG_DATA_W-1:0] cols_val;
        rst_n                     <= 1'b0;
        query_bus.valid           <= 1'b0;
        query_bus.key_rows        <= '0;
        query_bus.query_rows      <= '0;
        query_bus.queried_columns <= '0;
        cfg_bus.valid             <= 1'b0;
        cfg_bus.index             <= '0;
        cfg_bus.data              <= '0;
        result_bus.ready          <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        recv_idle_pct = 20;

        // reset settings: ghosting off, data passes through
        offer_query('{64'hFFFF_FFFF_FFFF_FFFF, 8'h01, 8'h0F});
        offer_query('{64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'hFF});
        finish_phase();

        write_reg(REG_UNUSED, 8'h01);
        set_config(8'h01, 8'h08);
        offer_query('{64'h0000_0000_0000_0000, 8'h00, 8'h01});
        offer_query('{64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'h00});
        offer_query('{64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'hFF});
        // chain of rows passing one column on to the next
        offer_query('{64'h0000_0018_0C06_0301, 8'h01, 8'h01});
        // every row a node, nothing queried
        offer_query('{64'h8181_4242_2424_1818, 8'h00, 8'h18});
        offer_query('{64'h8181_8181_8181_8181, 8'h00, 8'h01});
        // single-key rows never bridge
        offer_query('{64'h0102_0408_1020_4080, 8'h00, 8'h01});
        offer_query('{64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'h10});
        offer_query('{64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'h80});
        offer_query('{64'hAAAA_AAAA_AAAA_AAAA, 8'h55, 8'hAA});
        offer_query('{64'h5555_5555_5555_5555, 8'hAA, 8'h55});
        finish_phase();

        // zero column count
        set_config(8'h01, 8'h00);
        offer_query('{64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'hFF});
        offer_query('{64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'h01});
        finish_phase();

        // column count above the matrix width saturates
        set_config(8'hFF, 8'hFF);
        offer_query('{64'h0000_0018_0C06_0301, 8'h01, 8'h01});
        offer_query('{64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'h7F});
        finish_phase();

        set_config(8'h01, 8'h03);
        offer_query('{64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'h07});
        offer_query('{64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'h01});
        offer_query('{64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'hF8});
        offer_query('{64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'h08});
        finish_phase();

        set_config(8'hFE, 8'h09);
        offer_query('{64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'h3C});
        offer_query('{64'h0000_0018_0C06_0301, 8'h01, 8'h01});
        finish_phase();

        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0: begin send_idle_pct = 17; recv_idle_pct = 63; end
                1: begin send_idle_pct = 63; recv_idle_pct = 17; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int sub = 0; sub < 6; sub++)
            begin
                en_val    = CFG_DATA_W'($urandom);
                en_val[0] = ($urandom_range(4) != 0);
                cols_val  = CFG_DATA_W'($urandom);
                case ($urandom_range(5))
                    0: cols_val[ACOLS_W-1:0] = 4'd0;
                    1: cols_val[ACOLS_W-1:0] = 4'd8;
                    2: cols_val[ACOLS_W-1:0] = 4'd15;
                    default: cols_val[ACOLS_W-1:0] = ACOLS_W'($urandom_range(15));
                endcase
                set_config(en_val, cols_val);
                // long receiver stall while requests keep coming
                if (mode == 2 && sub == 2)
                    hold_off_req = 1'b1;
                for (int i = 0; i < PHASE_ITEMS; i++)
                    offer_query(make_query());
                finish_phase();
            end
        end

        if (sb.errors == 0)
            $display("PASS keypad_ghost_key_resolver");
        else
            $display("FAIL keypad_ghost_key_resolver");
        $finish;
    end

endmodule
